[hw/rtl/isws_pkg.sv]
// Shared types and constants for the integer stack with search.
// Used by isws_mem and integer_stack_with_search; depends on nothing.
package isws_pkg;

    localparam int unsigned DEPTH  = 256;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W  = ADDR_W + 1;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned CAP_W  = 9;
    localparam int unsigned OUT_TDATA_W = 56;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    typedef enum logic [2:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_PEEK   = 3'd2,
        CMD_CLEAR  = 3'd3,
        CMD_SEARCH = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SEARCH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic                     re;
        logic [ADDR_W-1:0]        raddr;
    } t_mem_req;

endpackage

[hw/rtl/isws_mem.sv]
// Stack entry memory: one write port, one read port with registered data.
// Depends on isws_pkg for depth, widths and the request struct.
module isws_mem (
    input  logic                                  i_clk,
    input  isws_pkg::t_mem_req                    i_req,
    output logic signed [isws_pkg::DATA_W-1:0]    o_rdata
);

    logic signed [isws_pkg::DATA_W-1:0] r_mem [isws_pkg::DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            o_rdata <= r_mem[i_req.raddr];
        end
    end

endmodule

[hw/rtl/integer_stack_with_search.sv]
// Push, clear, unused codes and any empty pop, peek or search go IDLE to FINISH; pop and peek
// pass READ, search SEARCH (one entry compared per cycle, top first, by the single comparator
// behind the memory read port), then FINISH. The next transaction is accepted the cycle
// after the result enters the output register; a stalled output register holds the sequencer.
// Reset clears the count and sets the capacity to 256; entry memory is not cleared.
// Depends on isws_pkg and isws_mem.
module integer_stack_with_search (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [isws_pkg::CAP_W-1:0]           i_cfg_wdata,     // capacity
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [31:0]                          i_s_axis_tdata,  // value[31:0]
    input  logic [2:0]                           i_s_axis_tuser,  // cmd[2:0]
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // data[31:0], found_index[39:32], count[48:40], empty_res[49], full_res[50], zero[55:51]
    output logic [isws_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    output logic [1:0]                           o_m_axis_tuser   // status[1:0]
);

    isws_pkg::t_state                   r_state, n_state;
    logic [isws_pkg::CNT_W-1:0]         r_count, n_count;
    logic [isws_pkg::CAP_W-1:0]         r_capacity;
    logic [isws_pkg::ADDR_W-1:0]        r_idx, n_idx;
    logic signed [isws_pkg::DATA_W-1:0] r_value, n_value;
    isws_pkg::t_status                  r_res_status, n_res_status;
    logic signed [isws_pkg::DATA_W-1:0] r_res_data, n_res_data;
    logic [isws_pkg::ADDR_W-1:0]        r_res_fidx, n_res_fidx;
    logic                               r_out_valid, n_out_valid;
    logic [isws_pkg::OUT_TDATA_W-1:0]   r_out_tdata, n_out_tdata;
    logic [1:0]                         r_out_tuser, n_out_tuser;

    isws_pkg::t_mem_req                 mem_req;
    logic signed [isws_pkg::DATA_W-1:0] mem_rdata;
    logic [isws_pkg::CNT_W-1:0]         cap_eff;
    logic                               in_acc;
    logic                               full_now;
    isws_pkg::t_cmd                     in_cmd;

    isws_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    assign cap_eff  = (r_capacity > isws_pkg::CAP_W'(isws_pkg::DEPTH))
                      ? isws_pkg::CNT_W'(isws_pkg::DEPTH)
                      : isws_pkg::CNT_W'(r_capacity);
    assign full_now = (r_count >= cap_eff);
    assign in_cmd   = isws_pkg::t_cmd'(i_s_axis_tuser);
    assign o_s_axis_tready = (r_state == isws_pkg::S_IDLE);
    assign in_acc   = i_s_axis_tvalid && o_s_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_tuser;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_value      = r_value;
        n_res_status = r_res_status;
        n_res_data   = r_res_data;
        n_res_fidx   = r_res_fidx;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_tdata  = r_out_tdata;
        n_out_tuser  = r_out_tuser;
        mem_req      = '0;

        unique case (r_state)
            isws_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_value      = i_s_axis_tdata;
                    n_res_status = isws_pkg::ST_OK;
                    n_res_data   = '0;
                    n_res_fidx   = '0;
                    n_state      = isws_pkg::S_FINISH;
                    unique case (in_cmd)
                        isws_pkg::CMD_PUSH: begin
                            if (full_now) begin
                                n_res_status = isws_pkg::ST_OVERFLOW;
                            end else begin
                                mem_req.we    = 1'b1;
                                mem_req.waddr = r_count[isws_pkg::ADDR_W-1:0];
                                mem_req.wdata = i_s_axis_tdata;
                                n_count       = r_count + 1'b1;
                            end
                        end
                        isws_pkg::CMD_POP, isws_pkg::CMD_PEEK: begin
                            if (r_count == '0) begin
                                n_res_status = isws_pkg::ST_UNDERFLOW;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = isws_pkg::ADDR_W'(r_count - 1'b1);
                                n_state       = isws_pkg::S_READ;
                                if (in_cmd == isws_pkg::CMD_POP) begin
                                    n_count = r_count - 1'b1;
                                end
                            end
                        end
                        isws_pkg::CMD_CLEAR: begin
                            n_count = '0;
                        end
                        isws_pkg::CMD_SEARCH: begin
                            if (r_count == '0) begin
                                n_res_status = isws_pkg::ST_NOT_FOUND;
                            end else begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = isws_pkg::ADDR_W'(r_count - 1'b1);
                                n_idx         = isws_pkg::ADDR_W'(r_count - 1'b1);
                                n_state       = isws_pkg::S_SEARCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            isws_pkg::S_READ: begin
                n_res_data = mem_rdata;
                n_state    = isws_pkg::S_FINISH;
            end
            isws_pkg::S_SEARCH: begin
                if (mem_rdata == r_value) begin
                    n_res_fidx = r_idx;
                    n_state    = isws_pkg::S_FINISH;
                end else if (r_idx == '0) begin
                    n_res_status = isws_pkg::ST_NOT_FOUND;
                    n_state      = isws_pkg::S_FINISH;
                end else begin
                    mem_req.re    = 1'b1;
                    mem_req.raddr = r_idx - 1'b1;
                    n_idx         = r_idx - 1'b1;
                end
            end
            isws_pkg::S_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_tuser = r_res_status;
                    n_out_tdata = {5'b0, full_now, (r_count == '0), r_count,
                                   r_res_fidx, r_res_data};
                    n_state     = isws_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = isws_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= isws_pkg::S_IDLE;
            r_count     <= '0;
            r_capacity  <= isws_pkg::CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_value      <= n_value;
        r_res_status <= n_res_status;
        r_res_data   <= n_res_data;
        r_res_fidx   <= n_res_fidx;
        r_out_tdata  <= n_out_tdata;
        r_out_tuser  <= n_out_tuser;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= isws_pkg::CNT_W'(isws_pkg::DEPTH))
        else $error("stack count beyond depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_cmd == isws_pkg::CMD_PUSH && !full_now)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not grow the stack");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(r_state) == isws_pkg::S_FINISH)
        else $error("result presented outside finish state");

endmodule
